// ===== design/sefr_pkg.sv =====
// ----------------------------------------------------------------------------
// sefr_pkg
// Shared types and constants for the start/end delimited frame receiver.
// ----------------------------------------------------------------------------
package sefr_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic {
    CFG_START_CODE = 1'b0,
    CFG_END_CODE   = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } status_t;

  localparam byte_t START_CODE_RST = 8'hFD;
  localparam byte_t END_CODE_RST   = 8'hFE;

  typedef struct packed {
    status_t status;
    byte_t   header;
    byte_t   group_class;
    byte_t   option_0;
    byte_t   option_1;
    byte_t   option_2;
    byte_t   option_3;
  } result_t;

endpackage

// ===== design/sefr_in_if.sv =====
// ----------------------------------------------------------------------------
// sefr_in_if
// Valid/ready channel that carries one received byte per word.
// ----------------------------------------------------------------------------
interface sefr_in_if;

  logic            valid;
  logic            ready;
  sefr_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);

endinterface

// ===== design/sefr_out_if.sv =====
// ----------------------------------------------------------------------------
// sefr_out_if
// Valid/ready channel that carries one frame result per word.
// ----------------------------------------------------------------------------
interface sefr_out_if;

  logic              valid;
  logic              ready;
  sefr_pkg::status_t status;
  sefr_pkg::byte_t   header;
  sefr_pkg::byte_t   group_class;
  sefr_pkg::byte_t   option_0;
  sefr_pkg::byte_t   option_1;
  sefr_pkg::byte_t   option_2;
  sefr_pkg::byte_t   option_3;

  modport source (
    output valid, output status, output header, output group_class,
    output option_0, output option_1, output option_2, output option_3,
    input ready
  );
  modport sink (
    input valid, input status, input header, input group_class,
    input option_0, input option_1, input option_2, input option_3,
    output ready
  );

endinterface

// ===== design/sefr_frame_ctrl.sv =====
// ----------------------------------------------------------------------------
// sefr_frame_ctrl
// Frame state, byte index and frame store; decodes one byte per accepted word
// and produces at most one result in the same cycle.
// ----------------------------------------------------------------------------
module sefr_frame_ctrl #(
  parameter int BUFFER_DEPTH = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  sefr_pkg::byte_t   rx_byte,
  input  sefr_pkg::byte_t   start_code,
  input  sefr_pkg::byte_t   end_code,
  output logic              res_valid,
  output sefr_pkg::result_t res
);

  localparam int IDX_W = $clog2(BUFFER_DEPTH);

  logic                  in_frame_r;
  logic                  in_frame_nxt;
  logic [IDX_W-1:0]      byte_index_r;
  logic [IDX_W-1:0]      byte_index_nxt;
  sefr_pkg::byte_t       store_r   [BUFFER_DEPTH];
  sefr_pkg::byte_t       store_nxt [BUFFER_DEPTH];
  sefr_pkg::byte_t       view      [BUFFER_DEPTH];
  logic [IDX_W-1:0]      next_idx;
  logic                  full;

  assign next_idx = byte_index_r + IDX_W'(1);
  assign full     = (byte_index_r == IDX_W'(BUFFER_DEPTH - 1));

  always_comb begin
    for (int k = 0; k < BUFFER_DEPTH; k++) begin
      view[k] = (next_idx == IDX_W'(k)) ? rx_byte : store_r[k];
    end
  end

  always_comb begin
    in_frame_nxt   = in_frame_r;
    byte_index_nxt = byte_index_r;
    store_nxt      = store_r;
    res_valid      = 1'b0;
    res            = '0;
    res.status     = sefr_pkg::STATUS_ERR;
    if (accept) begin
      if (!in_frame_r) begin
        if (rx_byte == start_code) begin
          store_nxt[0]   = rx_byte;
          in_frame_nxt   = 1'b1;
          byte_index_nxt = '0;
        end else begin
          store_nxt[0] = '0;
          res_valid    = 1'b1;
        end
      end else if (full) begin
        in_frame_nxt = 1'b0;
        store_nxt[0] = '0;
        res_valid    = 1'b1;
      end else begin
        store_nxt      = view;
        byte_index_nxt = next_idx;
        if (rx_byte == start_code) begin
          store_nxt[0]   = rx_byte;
          byte_index_nxt = '0;
        end else if (rx_byte == end_code) begin
          in_frame_nxt    = 1'b0;
          res_valid       = 1'b1;
          res.status      = sefr_pkg::STATUS_OK;
          res.header      = view[1];
          res.group_class = view[2];
          res.option_0    = view[3];
          res.option_1    = view[4];
          res.option_2    = view[5];
          res.option_3    = view[6];
          for (int k = 0; k < BUFFER_DEPTH; k++) begin
            store_nxt[k] = '0;
          end
          byte_index_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      byte_index_r <= '0;
      for (int k = 0; k < BUFFER_DEPTH; k++) begin
        store_r[k] <= '0;
      end
    end else begin
      in_frame_r   <= in_frame_nxt;
      byte_index_r <= byte_index_nxt;
      store_r      <= store_nxt;
    end
  end

endmodule

// ===== design/sefr_out_reg.sv =====
// ----------------------------------------------------------------------------
// sefr_out_reg
// Result register on the output channel; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module sefr_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sefr_pkg::result_t res,
  output logic              space,
  sefr_out_if.source        out_if
);

  logic              valid_r;
  logic              valid_nxt;
  sefr_pkg::result_t res_r;

  assign space = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      res_r <= res;
    end
  end

  assign out_if.valid       = valid_r;
  assign out_if.status      = res_r.status;
  assign out_if.header      = res_r.header;
  assign out_if.group_class = res_r.group_class;
  assign out_if.option_0    = res_r.option_0;
  assign out_if.option_1    = res_r.option_1;
  assign out_if.option_2    = res_r.option_2;
  assign out_if.option_3    = res_r.option_3;

endmodule

// ===== design/start_end_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// start_end_frame_receiver_core
// Deframes a byte stream delimited by a start code and an end code.
// ----------------------------------------------------------------------------
// Received bytes enter on in_if, one byte per word. A start byte opens a
// frame, later bytes are stored, and an end byte closes the frame with an OK
// word on out_if that carries stored bytes 1 to 6. A stray byte while idle or
// a byte that finds the store full gives an error word with zero data.
// The user must write the start and end codes through cfg_we, cfg_idx and
// cfg_wdata only while no frame traffic is pending; the block itself does
// not enforce this. Every byte is decoded in the cycle it is accepted; any
// result word is registered and shows on out_if in the next cycle. One byte
// per cycle is sustained while out_if keeps up; the single result register
// sets that figure and refills in the cycle that out_if drains it.
// When the downstream sink holds out_if.ready low with a word pending, in_if.ready
// drops until the word is taken. Reset clears the frame state and the store
// and sets the codes to 0xFD and 0xFE.
// ----------------------------------------------------------------------------
module start_end_frame_receiver_core #(
  parameter int BUFFER_DEPTH = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  sefr_pkg::cfg_idx_t   cfg_idx,
  input  sefr_pkg::byte_t      cfg_wdata,
  sefr_in_if.sink              in_if,
  sefr_out_if.source           out_if
);

  sefr_pkg::byte_t   start_code_r;
  sefr_pkg::byte_t   end_code_r;
  logic              space;
  logic              accept;
  logic              res_valid;
  sefr_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= sefr_pkg::START_CODE_RST;
      end_code_r   <= sefr_pkg::END_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        sefr_pkg::CFG_START_CODE: start_code_r <= cfg_wdata;
        sefr_pkg::CFG_END_CODE:   end_code_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_if.ready = space;
  assign accept      = in_if.valid && space;

  sefr_frame_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_frame_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_if.rx_byte),
    .start_code(start_code_r),
    .end_code  (end_code_r),
    .res_valid (res_valid),
    .res       (res)
  );

  sefr_out_reg u_out_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (res_valid),
    .res   (res),
    .space (space),
    .out_if(out_if)
  );

endmodule
